[rtl/core/rcavg_pkg.sv]
// Shared types and constants for the receiver channel averaging block.
package rcavg_pkg;

  localparam int CHANNELS   = 8;
  localparam int HIST_DEPTH = 4;
  localparam int SLOT_W     = $clog2(HIST_DEPTH);
  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = SAMPLE_W + SLOT_W;
  localparam int FRAME_W    = CHANNELS * SAMPLE_W;
  localparam int DATA_W     = ((FRAME_W + 7) / 8) * 8;

  localparam logic [SAMPLE_W:0] DEADBAND  = (SAMPLE_W + 1)'(3);
  localparam logic [SAMPLE_W-1:0] PULL_BACK = SAMPLE_W'(2);
  localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'(HIST_DEPTH / 2);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  // Control broadcast from the top level to every channel slice.
  typedef struct packed {
    logic  adv;     // stage contents move into the result registers
    logic  bypass;  // raw samples pass straight through
    slot_t slot;    // history slot written by this frame
  } ctl_t;

endpackage

[rtl/core/rcavg_chan.sv]
// One channel slice: four-deep history, rounded mean and deadband hold register.
module rcavg_chan (
  input  logic               clk,
  input  logic               rst_n,
  input  rcavg_pkg::ctl_t    ctl,
  input  rcavg_pkg::sample_t sample,
  output rcavg_pkg::sample_t value
);

  rcavg_pkg::sample_t hist_r [rcavg_pkg::HIST_DEPTH];
  rcavg_pkg::sample_t held_r;
  rcavg_pkg::sample_t held_nxt;

  logic [rcavg_pkg::SUM_W-1:0]    sum;
  rcavg_pkg::sample_t             mean;
  logic [rcavg_pkg::SAMPLE_W:0]   mean_ext;
  logic [rcavg_pkg::SAMPLE_W:0]   held_ext;

  // The new sample replaces the entry at the current slot before summing.
  always_comb begin
    sum = '0;
    for (int k = 0; k < rcavg_pkg::HIST_DEPTH; k++) begin
      if (ctl.slot == rcavg_pkg::SLOT_W'(k)) begin
        sum = sum + rcavg_pkg::SUM_W'(sample);
      end else begin
        sum = sum + rcavg_pkg::SUM_W'(hist_r[k]);
      end
    end
  end

  assign mean     = rcavg_pkg::SAMPLE_W'((sum + rcavg_pkg::ROUND_ADD) >> rcavg_pkg::SLOT_W);
  assign mean_ext = {1'b0, mean};
  assign held_ext = {1'b0, held_r};

  always_comb begin
    held_nxt = held_r;
    if (ctl.bypass) begin
      held_nxt = sample;
    end else if (mean_ext + rcavg_pkg::DEADBAND < held_ext) begin
      held_nxt = mean + rcavg_pkg::PULL_BACK;
    end else if (mean_ext > held_ext + rcavg_pkg::DEADBAND) begin
      held_nxt = mean - rcavg_pkg::PULL_BACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      for (int k = 0; k < rcavg_pkg::HIST_DEPTH; k++) begin
        hist_r[k] <= '0;
      end
    end else if (ctl.adv) begin
      held_r <= held_nxt;
      if (!ctl.bypass) begin
        hist_r[ctl.slot] <= sample;
      end
    end
  end

  assign value = held_r;

endmodule

[rtl/core/rc_channel_average_deadband.sv]
// Top level of the receiver channel smoothing block: handshakes, slot pointer, slices.
//
//   Channel  Direction  Payload (tdata, lowest bits first)            Extras
//   in_      slave      sample_ch0 .. sample_ch7, 12 bits each        none
//   out_     master     value_ch0 .. value_ch7, 12 bits each          none
//   cfg_     write only cfg_wdata = serial_bypass                     cfg_wr_en
//
// One frame is accepted per cycle while out_tready stays high. A frame is captured
// into the input stage register on its transfer and moves into the held registers
// of the slices when the stage advances; the single pass through the four-term sum
// and the deadband compare in each slice sets the cycle time.
// Reset clears the history, the held values, the slot pointer and the bypass bit.
// When the output is stalled, the output and the input stage both hold, and the
// input side keeps accepting until the input stage is full.
module rc_channel_average_deadband (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wdata,     // serial_bypass
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [rcavg_pkg::DATA_W-1:0] in_tdata,      // sample_ch0 .. sample_ch7
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rcavg_pkg::DATA_W-1:0] out_tdata      // value_ch0 .. value_ch7
);

  logic                          bypass_r;
  logic                          stage_valid_r;
  logic [rcavg_pkg::FRAME_W-1:0] stage_data_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  rcavg_pkg::slot_t              slot_r;
  rcavg_pkg::slot_t              slot_nxt;
  logic                          adv;
  logic                          in_xfer;
  rcavg_pkg::ctl_t               ctl;
  logic [rcavg_pkg::FRAME_W-1:0] values;

  // The stage advances when it holds a frame and the result registers are empty or being drained.
  assign adv       = stage_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stage_valid_r || adv;
  assign in_xfer   = in_tvalid && in_tready;

  // The pointer steps before the write, so the first smoothed frame lands in slot 1.
  assign slot_nxt = (adv && !bypass_r) ? slot_r + rcavg_pkg::SLOT_W'(1) : slot_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign ctl.adv    = adv;
  assign ctl.bypass = bypass_r;
  assign ctl.slot   = slot_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r      <= 1'b0;
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      slot_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        bypass_r <= cfg_wdata;
      end
      if (in_xfer) begin
        stage_valid_r <= 1'b1;
      end else if (adv) begin
        stage_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
      slot_r      <= slot_nxt;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_data_r <= in_tdata[rcavg_pkg::FRAME_W-1:0];
    end
  end

  for (genvar ch = 0; ch < rcavg_pkg::CHANNELS; ch++) begin : g_chan
    rcavg_chan u_chan (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .sample (stage_data_r[ch*rcavg_pkg::SAMPLE_W +: rcavg_pkg::SAMPLE_W]),
      .value  (values[ch*rcavg_pkg::SAMPLE_W +: rcavg_pkg::SAMPLE_W])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rcavg_pkg::DATA_W'(values);

`ifndef SYNTHESIS
  a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && !bypass_r) |=> $stable(slot_r))
    else $error("slot pointer moved without a smoothed frame");

  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !bypass_r |=> slot_r == $past(slot_r) + rcavg_pkg::SLOT_W'(1))
    else $error("slot pointer did not step by one");

  a_bypass_pass: assert property (@(posedge clk) disable iff (!rst_n)
    adv && bypass_r |=> values == $past(stage_data_r))
    else $error("bypass frame not passed through unchanged");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready && !adv |=> out_valid_r && $stable(values))
    else $error("stalled result lost or changed");

  a_stage_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !stage_valid_r |-> in_tready)
    else $error("input refused while the stage is empty");
`endif

endmodule
